@@ rtl/rwhp_pkg.sv @@
// ----------------------------------------------------------------------------
// rwhp_pkg
// Types and constants shared by the RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
package rwhp_pkg;

    localparam int OFFSET_BITS = 36;
    localparam int DOFF_BITS   = 36;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam int POS_RIFF_END = 3;
    localparam int POS_WAVE_END = 11;
    localparam int POS_FMT_END  = 15;
    localparam int POS_HDR_END  = 19;
    localparam int FMT_BASE     = 20;

    localparam logic [31:0] FMT_MIN = 32'd16;

    localparam logic [2:0] PH_HEADER     = 3'd0;
    localparam logic [2:0] PH_FMT        = 3'd1;
    localparam logic [2:0] PH_FMT_SKIP   = 3'd2;
    localparam logic [2:0] PH_CHUNK_HDR  = 3'd3;
    localparam logic [2:0] PH_CHUNK_SKIP = 3'd4;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_TAG   = 3'd1;
    localparam logic [2:0] ERR_NO_FMT    = 3'd2;
    localparam logic [2:0] ERR_FMT_SMALL = 3'd3;
    localparam logic [2:0] ERR_TRUNC     = 3'd4;

    localparam logic [3:0] HDR_TAG_DONE  = 4'd4;
    localparam logic [3:0] HDR_SIZE_DONE = 4'd8;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       final_byte;
    } byte_beat_t;

    typedef struct packed {
        logic                 ok;
        logic [2:0]           error_code;
        logic [15:0]          audio_format;
        logic [15:0]          channel_count;
        logic [31:0]          sample_rate;
        logic [31:0]          byte_rate;
        logic [15:0]          block_align;
        logic [15:0]          sample_bits;
        logic [31:0]          data_size;
        logic [DOFF_BITS-1:0] data_offset;
    } hdr_result_t;

endpackage

@@ rtl/riff_wave_header_parser_core.sv @@
// ----------------------------------------------------------------------------
// riff_wave_header_parser_core
// Parses a RIFF/WAVE header from a byte stream and reports the fmt fields
// and the location of the data chunk, or an error code.
// ----------------------------------------------------------------------------
//  channel   valid       stall       payload
//  input     byte_valid  byte_stall  byte_data (byte_in, final_byte)
//  result    hdr_valid   hdr_stall   hdr_data  (hdr_result_t)
//
//  one byte per cycle while byte_stall is low; a result is registered in
//  res_reg after the byte that decides it, or in the skid entry if stalled
//  a two-entry output buffer lets bytes flow while a result is stalled;
//  byte_stall rises only when both entries are full
//  rst_n clears parse state and the output buffer asynchronously
// ----------------------------------------------------------------------------
module riff_wave_header_parser_core
    import rwhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  byte_beat_t  byte_data,
    output logic        hdr_valid,
    input  logic        hdr_stall,
    output hdr_result_t hdr_data
);

    localparam logic [OFFSET_BITS-1:0] POS_MAX  = {OFFSET_BITS{1'b1}};
    localparam logic [DOFF_BITS-1:0]   DOFF_MAX = {DOFF_BITS{1'b1}};

    logic [2:0]             phase_reg,   phase_next;
    logic [OFFSET_BITS-1:0] pos_reg,     pos_next;
    logic [31:0]            shift_reg,   shift_next;
    logic [31:0]            flen_reg,    flen_next;
    logic [32:0]            skip_reg,    skip_next;
    logic [3:0]             hdr_cnt_reg, hdr_cnt_next;
    logic                   sent_reg,    sent_next;
    logic [7:0][7:0]        fmt0_reg,    fmt0_next;
    logic [7:0][7:0]        fmt1_reg,    fmt1_next;

    logic                   res_valid_reg,  res_valid_next;
    hdr_result_t            res_reg,        res_next;
    logic                   skid_valid_reg, skid_valid_next;
    hdr_result_t            skid_reg,       skid_next;

    logic                   accept;
    logic                   fin;
    logic                   emit;
    logic                   ok;
    logic [2:0]             err;
    logic [31:0]            dsize;
    logic                   have_fmt;
    logic [3:0]             fmt_k;
    logic [3:0]             hdr_cnt_inc;
    logic [32:0]            skip_dec;
    logic                   out_free;
    hdr_result_t            result;

    assign accept     = byte_valid & ~byte_stall;
    assign fin        = byte_data.final_byte;
    assign byte_stall = skid_valid_reg;
    assign hdr_valid  = res_valid_reg;
    assign hdr_data   = res_reg;
    assign out_free   = ~res_valid_reg | ~hdr_stall;

    assign fmt_k       = pos_reg[3:0] - 4'(FMT_BASE);
    assign hdr_cnt_inc = hdr_cnt_reg + 4'd1;
    assign skip_dec    = (skip_reg != 33'd0) ? skip_reg - 33'd1 : skip_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        shift_next   = shift_reg;
        flen_next    = flen_reg;
        skip_next    = skip_reg;
        hdr_cnt_next = hdr_cnt_reg;
        sent_next    = sent_reg;
        fmt0_next    = fmt0_reg;
        fmt1_next    = fmt1_reg;
        emit         = 1'b0;
        ok           = 1'b0;
        err          = ERR_NONE;
        dsize        = 32'd0;
        have_fmt     = 1'b0;
        result       = '0;

        if (accept)
        begin
            if (sent_reg)
            begin
                if (fin)
                begin
                    phase_next   = PH_HEADER;
                    pos_next     = '0;
                    shift_next   = '0;
                    flen_next    = '0;
                    skip_next    = '0;
                    hdr_cnt_next = '0;
                    sent_next    = 1'b0;
                end
            end
            else
            begin
                pos_next   = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
                shift_next = {byte_data.byte_in, shift_reg[31:8]};

                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (pos_reg == OFFSET_BITS'(POS_RIFF_END) && shift_next != TAG_RIFF)
                        begin
                            emit = 1'b1;
                            err  = ERR_BAD_TAG;
                        end
                        else if (pos_reg == OFFSET_BITS'(POS_WAVE_END)
                                 && shift_next != TAG_WAVE)
                        begin
                            emit = 1'b1;
                            err  = ERR_BAD_TAG;
                        end
                        else if (pos_reg == OFFSET_BITS'(POS_FMT_END)
                                 && shift_next != TAG_FMT)
                        begin
                            emit = 1'b1;
                            err  = ERR_NO_FMT;
                        end
                        else if (pos_reg == OFFSET_BITS'(POS_HDR_END))
                        begin
                            flen_next = shift_next;
                            if (shift_next < FMT_MIN)
                            begin
                                emit = 1'b1;
                                err  = ERR_FMT_SMALL;
                            end
                            else
                            begin
                                phase_next = PH_FMT;
                            end
                        end
                    end
                    PH_FMT:
                    begin
                        if (fmt_k[3])
                        begin
                            fmt1_next[fmt_k[2:0]] = byte_data.byte_in;
                        end
                        else
                        begin
                            fmt0_next[fmt_k[2:0]] = byte_data.byte_in;
                        end
                        if (fmt_k == 4'hF)
                        begin
                            hdr_cnt_next = '0;
                            if (flen_reg > FMT_MIN)
                            begin
                                skip_next  = 33'(flen_reg) - 33'(FMT_MIN);
                                phase_next = PH_FMT_SKIP;
                            end
                            else
                            begin
                                phase_next = PH_CHUNK_HDR;
                            end
                        end
                    end
                    PH_FMT_SKIP, PH_CHUNK_SKIP:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == 33'd0)
                        begin
                            hdr_cnt_next = '0;
                            phase_next   = PH_CHUNK_HDR;
                        end
                    end
                    PH_CHUNK_HDR:
                    begin
                        hdr_cnt_next = hdr_cnt_inc;
                        if (hdr_cnt_inc == HDR_TAG_DONE)
                        begin
                            flen_next = shift_next;
                        end
                        else if (hdr_cnt_inc >= HDR_SIZE_DONE)
                        begin
                            hdr_cnt_next = '0;
                            if (flen_reg == TAG_DATA)
                            begin
                                emit  = 1'b1;
                                ok    = 1'b1;
                                dsize = shift_next;
                            end
                            else
                            begin
                                skip_next = {1'b0, shift_next} + 33'(shift_next[0]);
                                if (skip_next != 33'd0)
                                begin
                                    phase_next = PH_CHUNK_SKIP;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HEADER;
                    end
                endcase

                if (!emit && fin)
                begin
                    emit = 1'b1;
                    err  = ERR_TRUNC;
                end

                have_fmt = ok || (phase_next >= PH_CHUNK_HDR);
                result.ok         = ok;
                result.error_code = err;
                if (have_fmt)
                begin
                    result.audio_format  = {fmt0_next[1], fmt0_next[0]};
                    result.channel_count = {fmt0_next[3], fmt0_next[2]};
                    result.sample_rate   = {fmt0_next[7], fmt0_next[6],
                                            fmt0_next[5], fmt0_next[4]};
                    result.byte_rate     = {fmt1_next[3], fmt1_next[2],
                                            fmt1_next[1], fmt1_next[0]};
                    result.block_align   = {fmt1_next[5], fmt1_next[4]};
                    result.sample_bits   = {fmt1_next[7], fmt1_next[6]};
                end
                result.data_size = dsize;
                if (ok)
                begin
                    result.data_offset = (64'(pos_next) > 64'(DOFF_MAX))
                                         ? DOFF_MAX : DOFF_BITS'(64'(pos_next));
                end

                if (emit)
                begin
                    if (fin)
                    begin
                        phase_next   = PH_HEADER;
                        pos_next     = '0;
                        shift_next   = '0;
                        flen_next    = '0;
                        skip_next    = '0;
                        hdr_cnt_next = '0;
                        sent_next    = 1'b0;
                    end
                    else
                    begin
                        sent_next = 1'b1;
                    end
                end
            end
        end
    end

    // two-entry output buffer
    always_comb
    begin
        res_valid_next  = res_valid_reg;
        res_next        = res_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                res_valid_next  = 1'b1;
                res_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (emit)
        begin
            if (out_free)
            begin
                res_valid_next = 1'b1;
                res_next       = result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = result;
            end
        end
        else if (out_free)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            pos_reg        <= '0;
            shift_reg      <= '0;
            flen_reg       <= '0;
            skip_reg       <= '0;
            hdr_cnt_reg    <= '0;
            sent_reg       <= 1'b0;
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            shift_reg      <= shift_next;
            flen_reg       <= flen_next;
            skip_reg       <= skip_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            sent_reg       <= sent_next;
            res_valid_reg  <= res_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fmt0_reg <= fmt0_next;
        fmt1_reg <= fmt1_next;
        res_reg  <= res_next;
        skid_reg <= skid_next;
    end

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> res_valid_reg)
        else $error("skid entry held without an output beat");

    a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_cnt_reg <= HDR_SIZE_DONE)
        else $error("chunk header counter out of range");

    a_header_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER && !sent_reg) |-> (pos_reg <= OFFSET_BITS'(POS_HDR_END)))
        else $error("header phase past fmt size field");

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FMT_SKIP || phase_reg == PH_CHUNK_SKIP) |-> (skip_reg != 33'd0))
        else $error("skip phase with nothing left to skip");

endmodule
